// File: rtl/muscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muscc_pkg
// shared types, constants and the pitch table of the melody string compiler
// ----------------------------------------------------------------------------
package muscc_pkg;

  typedef enum logic [1:0] {
    KIND_TONE  = 2'd0,
    KIND_PAUSE = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_TOP, PH_NUM_L, PH_NUM_N, PH_NUM_O, PH_NUM_P, PH_NUM_T,
    PH_OPT, PH_NOTE_HEAD, PH_NOTE_ACC, PH_NOTE_DIG, PH_NOTE_DOTS
  } phase_e;

  typedef enum logic [1:0] {FS_IDLE, FS_CHAR, FS_END, FS_DONE} fst_e;

  typedef enum logic [1:0] {BS_IDLE, BS_DIV1, BS_DIV2, BS_OUT} bst_e;

  localparam int unsigned DivW = 18;
  localparam logic [DivW-1:0] WholeNoteMs = 18'd240000;

  localparam logic [2:0] FracStaccato = 3'd5;
  localparam logic [2:0] FracNormal   = 3'd6;
  localparam logic [2:0] FracLegato   = 3'd7;
  localparam logic [2:0] OctaveDef    = 3'd4;
  localparam logic [2:0] OctaveMax    = 3'd6;
  localparam logic [5:0] LengthDef    = 6'd4;
  localparam logic [7:0] TempoDef     = 8'd120;

  // queued work item between parser and duration unit
  typedef struct packed {
    kind_e       kind;
    logic [18:0] freq;
    logic [5:0]  len;
    logic [1:0]  dots;
    logic [7:0]  tempo;
    logic [2:0]  frac;
    logic [15:0] epos;
    logic        last;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [18:0] freq;
    logic [13:0] dur;
    logic [2:0]  frac;
    logic [15:0] epos;
    logic        last;
  } res_t;

  // lowest octave pitches in centihertz
  function automatic logic [12:0] base_cents(input logic [3:0] note);
    logic [12:0] r;
    unique case (note)
      4'd0:    r = 13'd3270;
      4'd1:    r = 13'd3465;
      4'd2:    r = 13'd3671;
      4'd3:    r = 13'd3889;
      4'd4:    r = 13'd4120;
      4'd5:    r = 13'd4365;
      4'd6:    r = 13'd4625;
      4'd7:    r = 13'd4900;
      4'd8:    r = 13'd5191;
      4'd9:    r = 13'd5500;
      4'd10:   r = 13'd5827;
      4'd11:   r = 13'd6174;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/music_macro_string_compiler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// music_macro_string_compiler
// play-string compiler: characters in, tones, pauses, end and error words out
// ----------------------------------------------------------------------------
// Characters are pushed one at a time; lower case is folded to upper case.
// The parser works on one character at a time and waits for room in the queue
// when it must (a character that closes a command or note is parsed more than
// once, and the final one also runs the end pass unless an error is pending).
// It queues a word for each note, pause, end marker or syntax error. Each note
// or pause then goes through the duration unit, whose single
// restoring divider does 240000/length and then /tempo at one bit a cycle.
// The queue of CmdDepth words between parser and duration unit lets the
// parser run ahead. run_last flags the last word caused by one character;
// after a syntax error nothing comes out until the final character, which
// rearms the block.
module music_macro_string_compiler #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        final_char_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [18:0] freq_centihertz_o,
  output logic [13:0] duration_ms_o,
  output logic [2:0]  fraction_code_o,
  output logic [15:0] error_position_o,
  output logic        run_last_o
);
  import muscc_pkg::*;

  // parser to queue
  logic cq_push, cq_full;
  cmd_t cq_wdata;
  // queue to duration unit
  logic cq_pop, cq_empty;
  cmd_t cq_rdata;
  res_t res;

  muscc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .char_i    (char_code_i),
    .final_i   (final_char_i),
    .full_o    (full),
    .cq_push_o (cq_push),
    .cq_data_o (cq_wdata),
    .cq_full_i (cq_full)
  );

  muscc_cmdq #(
    .Depth (CmdDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .data_i  (cq_wdata),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .empty_o (cq_empty),
    .data_o  (cq_rdata)
  );

  muscc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cq_empty_i (cq_empty),
    .cq_data_i  (cq_rdata),
    .cq_pop_o   (cq_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  // result word fields
  assign kind_o            = res.kind;
  assign freq_centihertz_o = res.freq;
  assign duration_ms_o     = res.dur;
  assign fraction_code_o   = res.frac;
  assign error_position_o  = res.epos;
  assign run_last_o        = res.last;

  // the parser only pushes when the queue has room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_push |-> !cq_full) else $error("command queue overflow");

  // an end marker is always the last word of its character
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_END) |-> run_last_o) else $error("end word not last");

  // error words carry no duration
  a_err_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_ERROR) |-> duration_ms_o == 14'd0)
    else $error("error word with duration");

endmodule
`default_nettype wire

// File: rtl/muscc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muscc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module muscc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [muscc_pkg::DivW-1:0]  dvd_i,
  input  logic [7:0]                  dvs_i,
  output logic                        done_o,
  output logic [muscc_pkg::DivW-1:0]  quo_o
);
  import muscc_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      rem_q, dvs_q;
  logic [DivW-1:0] dq_q;
  logic [8:0]      rem_s;
  logic            ge;

  assign rem_s = {rem_q, dq_q[DivW-1]};
  assign ge    = rem_s >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dvd_i;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= ge ? 8'(rem_s - {1'b0, dvs_q}) : rem_s[7:0];
      dq_q  <= {dq_q[DivW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = dq_q;

endmodule
`default_nettype wire

// File: rtl/muscc_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muscc_cmdq
// short queue of parsed words between the parser and the duration unit
// ----------------------------------------------------------------------------
module muscc_cmdq #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  muscc_pkg::cmd_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output muscc_pkg::cmd_t  data_o
);
  import muscc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop)  rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

// File: rtl/muscc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muscc_front
// character parser: keeps the play state and queues one word per note,
// pause, end marker or syntax error
// ----------------------------------------------------------------------------
module muscc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       char_i,
  input  logic             final_i,
  output logic             full_o,
  output logic             cq_push_o,
  output muscc_pkg::cmd_t  cq_data_o,
  input  logic             cq_full_i
);
  import muscc_pkg::*;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  // value mod 7, summing octal digits since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [15:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    return (s3 == 4'd7) ? 3'd0 : s3[2:0];
  endfunction

  function automatic cmd_t mk_sound(input logic [3:0] note, input logic [2:0] oct,
                                    input logic [5:0] len, input logic [1:0] dots,
                                    input logic [7:0] tempo, input logic [2:0] frac);
    cmd_t c;
    c       = '0;
    c.len   = len;
    c.dots  = dots;
    c.tempo = tempo;
    c.frac  = frac;
    if (note > 4'd11 || oct > OctaveMax) begin
      c.kind = KIND_PAUSE;
    end else begin
      c.kind = KIND_TONE;
      c.freq = 19'(base_cents(note)) << oct;
    end
    return c;
  endfunction

  function automatic cmd_t mk_fail(input logic [15:0] pos);
    cmd_t c;
    c      = '0;
    c.kind = KIND_ERROR;
    c.epos = pos;
    return c;
  endfunction

  fst_e        fst_q, fst_d;
  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic        dig_q, dig_d;
  logic [3:0]  pnote_q, pnote_d;
  logic [2:0]  poct_q, poct_d;
  logic [5:0]  plen_q, plen_d;
  logic [1:0]  dots_q, dots_d;
  logic [2:0]  coct_q, coct_d;
  logic [5:0]  clen_q, clen_d;
  logic [7:0]  ctempo_q, ctempo_d;
  logic [2:0]  cfrac_q, cfrac_d;
  logic        err_q, err_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  ch_q, ch_d;
  logic        fin_q, fin_d;
  cmd_t        held_q, held_d;
  logic        held_v_q, held_v_d;

  logic        isend, is_dig, consumed, em;
  cmd_t        em_cmd;
  logic [3:0]  dval;
  logic [19:0] acc_sum;
  logic [15:0] acc_next;
  logic [6:0]  nm1;
  logic [12:0] nprod;
  logic [2:0]  n_oct;
  logic [3:0]  n_note;
  logic [5:0]  sat_len;
  logic [15:0] kpos;

  assign isend    = fst_q == FS_END;
  assign is_dig   = !isend && ch_q >= ChZero && ch_q <= ChNine;
  assign dval     = 4'(ch_q - ChZero);
  assign acc_sum  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 20'(dval);
  assign acc_next = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];
  // note number split into octave and semitone, 43/512 stands in for 1/12
  assign nm1      = 7'(acc_q - 16'd1);
  assign nprod    = 13'(nm1) * 13'd43;
  assign n_oct    = nprod[11:9];
  assign n_note   = 4'(nm1 - 7'(n_oct) * 7'd12);
  assign sat_len  = (acc_q > 16'd63) ? 6'd63 : acc_q[5:0];
  assign kpos     = idx_q + 16'd1;
  assign full_o   = fst_q != FS_IDLE;

  always_comb begin
    fst_d    = fst_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    dig_d    = dig_q;
    pnote_d  = pnote_q;
    poct_d   = poct_q;
    plen_d   = plen_q;
    dots_d   = dots_q;
    coct_d   = coct_q;
    clen_d   = clen_q;
    ctempo_d = ctempo_q;
    cfrac_d  = cfrac_q;
    err_d    = err_q;
    idx_d    = idx_q;
    ch_d     = ch_q;
    fin_d    = fin_q;
    held_d   = held_q;
    held_v_d = held_v_q;
    consumed = 1'b0;
    em       = 1'b0;
    em_cmd   = '0;
    cq_push_o = 1'b0;
    cq_data_o = held_q;

    unique case (fst_q)
      FS_IDLE: begin
        if (push_i) begin
          ch_d  = (char_i >= ChLowA && char_i <= ChLowZ) ? char_i - CaseGap : char_i;
          fin_d = final_i;
          fst_d = err_q ? FS_DONE : FS_CHAR;
        end
      end

      FS_CHAR, FS_END: begin
        if (!(held_v_q && cq_full_i)) begin
          unique case (phase_q)
            PH_TOP: begin
              consumed = 1'b1;
              if (isend) begin
                em          = 1'b1;
                em_cmd      = '0;
                em_cmd.kind = KIND_END;
              end else begin
                priority case (ch_q)
                  ChSpace: ;
                  ChL, ChN, ChO, ChP, ChT: begin
                    priority case (ch_q)
                      ChL:     phase_d = PH_NUM_L;
                      ChN:     phase_d = PH_NUM_N;
                      ChO:     phase_d = PH_NUM_O;
                      ChP:     phase_d = PH_NUM_P;
                      default: phase_d = PH_NUM_T;
                    endcase
                    acc_d = '0;
                    dig_d = 1'b0;
                  end
                  ChM: phase_d = PH_OPT;
                  ChLt: if (coct_q != 3'd0) coct_d = coct_q - 3'd1;
                  ChGt: if (coct_q < OctaveMax) coct_d = coct_q + 3'd1;
                  ChC, ChD, ChE, ChF, ChG, ChA, ChB: begin
                    priority case (ch_q)
                      ChC:     pnote_d = 4'd0;
                      ChD:     pnote_d = 4'd2;
                      ChE:     pnote_d = 4'd4;
                      ChF:     pnote_d = 4'd5;
                      ChG:     pnote_d = 4'd7;
                      ChA:     pnote_d = 4'd9;
                      default: pnote_d = 4'd11;
                    endcase
                    poct_d  = coct_q;
                    plen_d  = clen_q;
                    dots_d  = 2'd0;
                    phase_d = PH_NOTE_HEAD;
                  end
                  default: begin
                    em     = 1'b1;
                    em_cmd = mk_fail(kpos);
                    err_d  = 1'b1;
                  end
                endcase
              end
            end

            PH_NUM_L, PH_NUM_N, PH_NUM_O, PH_NUM_P, PH_NUM_T: begin
              if (is_dig) begin
                acc_d    = acc_next;
                dig_d    = 1'b1;
                consumed = 1'b1;
              end else if (!dig_q) begin
                em       = 1'b1;
                em_cmd   = mk_fail(idx_q);
                err_d    = 1'b1;
                phase_d  = PH_TOP;
                consumed = 1'b1;
              end else begin
                // command complete; unless it is rejected, the character is parsed again at top level
                phase_d = PH_TOP;
                acc_d   = '0;
                dig_d   = 1'b0;
                unique case (phase_q)
                  PH_NUM_L: begin
                    if (acc_q != 16'd0) begin
                      if (acc_q[5:0] == 6'd0) begin
                        em = 1'b1; em_cmd = mk_fail(idx_q); err_d = 1'b1; consumed = 1'b1;
                      end else begin
                        clen_d = acc_q[5:0];
                      end
                    end
                  end
                  PH_NUM_N: begin
                    if (acc_q > 16'd84) begin
                      em = 1'b1; em_cmd = mk_fail(idx_q); err_d = 1'b1; consumed = 1'b1;
                    end else if (acc_q == 16'd0) begin
                      em     = 1'b1;
                      em_cmd = mk_sound(4'd12, 3'd0, clen_q, 2'd0, ctempo_q, cfrac_q);
                    end else begin
                      em     = 1'b1;
                      em_cmd = mk_sound(n_note, n_oct, clen_q, 2'd0, ctempo_q, cfrac_q);
                    end
                  end
                  PH_NUM_O: coct_d = mod7(acc_q);
                  PH_NUM_P: begin
                    if (sat_len == 6'd0) begin
                      em = 1'b1; em_cmd = mk_fail(idx_q); err_d = 1'b1; consumed = 1'b1;
                    end else begin
                      em           = 1'b1;
                      em_cmd       = '0;
                      em_cmd.kind  = KIND_PAUSE;
                      em_cmd.len   = sat_len;
                      em_cmd.tempo = ctempo_q;
                    end
                  end
                  default: begin
                    if (acc_q >= 16'd32 && acc_q < 16'd256) begin
                      ctempo_d = acc_q[7:0];
                    end else begin
                      em = 1'b1; em_cmd = mk_fail(idx_q); err_d = 1'b1; consumed = 1'b1;
                    end
                  end
                endcase
              end
            end

            PH_OPT: begin
              phase_d  = PH_TOP;
              consumed = 1'b1;
              if (!isend && ch_q == ChS)      cfrac_d = FracStaccato;
              else if (!isend && ch_q == ChL) cfrac_d = FracLegato;
              else if (!isend && ch_q == ChN) cfrac_d = FracNormal;
              else if (isend || (ch_q != ChB && ch_q != ChF)) begin
                em     = 1'b1;
                em_cmd = mk_fail(kpos);
                err_d  = 1'b1;
              end
            end

            PH_NOTE_HEAD: begin
              if (!isend && (ch_q == ChPlus || ch_q == ChHash)) begin
                if (pnote_q >= 4'd11 && poct_q < OctaveMax) begin
                  pnote_d = 4'd0;
                  poct_d  = poct_q + 3'd1;
                end else begin
                  pnote_d = pnote_q + 4'd1;
                end
                phase_d  = PH_NOTE_ACC;
                consumed = 1'b1;
              end else if (!isend && ch_q == ChMinus) begin
                if (pnote_q != 4'd0) pnote_d = pnote_q - 4'd1;
                else if (poct_q != 3'd0) begin
                  pnote_d = 4'd11;
                  poct_d  = poct_q - 3'd1;
                end else pnote_d = 4'd15;
                phase_d  = PH_NOTE_ACC;
                consumed = 1'b1;
              end else if (!isend && ch_q == ChDot) begin
                dots_d   = 2'd1;
                phase_d  = PH_NOTE_DOTS;
                consumed = 1'b1;
              end else if (is_dig) begin
                acc_d    = 16'(dval);
                dig_d    = 1'b1;
                phase_d  = PH_NOTE_DIG;
                consumed = 1'b1;
              end else begin
                em      = 1'b1;
                em_cmd  = mk_sound(pnote_q, poct_q, plen_q, dots_q, ctempo_q, cfrac_q);
                phase_d = PH_TOP;
              end
            end

            PH_NOTE_ACC: begin
              if (is_dig) begin
                acc_d    = 16'(dval);
                dig_d    = 1'b1;
                phase_d  = PH_NOTE_DIG;
                consumed = 1'b1;
              end else begin
                phase_d = PH_NOTE_DOTS;
              end
            end

            PH_NOTE_DIG: begin
              if (is_dig) begin
                acc_d    = acc_next;
                dig_d    = 1'b1;
                consumed = 1'b1;
              end else begin
                acc_d = '0;
                dig_d = 1'b0;
                if (sat_len == 6'd0) begin
                  em       = 1'b1;
                  em_cmd   = mk_fail(idx_q);
                  err_d    = 1'b1;
                  phase_d  = PH_TOP;
                  consumed = 1'b1;
                end else begin
                  plen_d  = sat_len;
                  phase_d = PH_NOTE_DOTS;
                end
              end
            end

            PH_NOTE_DOTS: begin
              if (!isend && ch_q == ChDot) begin
                if (dots_q != 2'd3) dots_d = dots_q + 2'd1;
                consumed = 1'b1;
              end else begin
                em      = 1'b1;
                em_cmd  = mk_sound(pnote_q, poct_q, plen_q, dots_q, ctempo_q, cfrac_q);
                phase_d = PH_TOP;
              end
            end

            default: phase_d = PH_TOP;
          endcase

          // one word is held back so the last of a character can be flagged
          if (em) begin
            if (held_v_q) begin
              cq_push_o      = 1'b1;
              cq_data_o      = held_q;
              cq_data_o.last = 1'b0;
            end
            held_d   = em_cmd;
            held_v_d = 1'b1;
          end

          if (consumed) begin
            if (fst_q == FS_CHAR) begin
              idx_d = idx_q + 16'd1;
              fst_d = (fin_q && !err_d) ? FS_END : FS_DONE;
            end else begin
              fst_d = FS_DONE;
            end
          end
        end
      end

      FS_DONE: begin
        if (!(held_v_q && cq_full_i)) begin
          if (held_v_q) begin
            cq_push_o      = 1'b1;
            cq_data_o      = held_q;
            cq_data_o.last = 1'b1;
            held_v_d       = 1'b0;
          end
          fst_d = FS_IDLE;
          if (fin_q) begin
            phase_d  = PH_TOP;
            acc_d    = '0;
            dig_d    = 1'b0;
            pnote_d  = 4'd0;
            poct_d   = 3'd0;
            plen_d   = LengthDef;
            dots_d   = 2'd0;
            coct_d   = OctaveDef;
            clen_d   = LengthDef;
            ctempo_d = TempoDef;
            cfrac_d  = FracNormal;
            err_d    = 1'b0;
            idx_d    = '0;
          end
        end
      end

      default: fst_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q    <= FS_IDLE;
      phase_q  <= PH_TOP;
      acc_q    <= '0;
      dig_q    <= 1'b0;
      pnote_q  <= 4'd0;
      poct_q   <= 3'd0;
      plen_q   <= LengthDef;
      dots_q   <= 2'd0;
      coct_q   <= OctaveDef;
      clen_q   <= LengthDef;
      ctempo_q <= TempoDef;
      cfrac_q  <= FracNormal;
      err_q    <= 1'b0;
      idx_q    <= '0;
      fin_q    <= 1'b0;
      held_v_q <= 1'b0;
    end else begin
      fst_q    <= fst_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      dig_q    <= dig_d;
      pnote_q  <= pnote_d;
      poct_q   <= poct_d;
      plen_q   <= plen_d;
      dots_q   <= dots_d;
      coct_q   <= coct_d;
      clen_q   <= clen_d;
      ctempo_q <= ctempo_d;
      cfrac_q  <= cfrac_d;
      err_q    <= err_d;
      idx_q    <= idx_d;
      fin_q    <= fin_d;
      held_v_q <= held_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    held_q <= held_d;
  end

endmodule
`default_nettype wire

// File: rtl/muscc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// muscc_back
// duration unit: two divisions on a shared divider, dot scaling, result queue
// ----------------------------------------------------------------------------
module muscc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cq_empty_i,
  input  muscc_pkg::cmd_t  cq_data_i,
  output logic             cq_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output muscc_pkg::res_t  res_o
);
  import muscc_pkg::*;

  bst_e        bst_q, bst_d;
  cmd_t        cmd_q, cmd_d;
  logic [12:0] t_q, t_d;
  logic        div_start, div_done;
  logic [DivW-1:0] div_dvd, div_quo;
  logic [7:0]  div_dvs;
  logic [14:0] t3;
  logic [15:0] t7;
  logic [13:0] dur;
  res_t        res_new;
  logic        oq_push, oq_full;

  res_t        oq_mem_q [2];
  logic        oq_wp_q, oq_rp_q;
  logic [1:0]  oq_cnt_q;

  muscc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign t3 = {1'b0, t_q, 1'b0} + 15'(t_q);
  assign t7 = {t_q, 3'b0} - 16'(t_q);

  always_comb begin
    unique case (cmd_q.dots)
      2'd1:    dur = 14'(t3 >> 1);
      2'd2:    dur = 14'(t7 >> 2);
      default: dur = 14'(t_q);
    endcase
    res_new.kind = cmd_q.kind;
    res_new.freq = cmd_q.freq;
    res_new.dur  = dur;
    res_new.frac = cmd_q.frac;
    res_new.epos = cmd_q.epos;
    res_new.last = cmd_q.last;
  end

  always_comb begin
    bst_d     = bst_q;
    cmd_d     = cmd_q;
    t_d       = t_q;
    cq_pop_o  = 1'b0;
    div_start = 1'b0;
    div_dvd   = WholeNoteMs;
    div_dvs   = {2'b0, cq_data_i.len};
    oq_push   = 1'b0;
    unique case (bst_q)
      BS_IDLE: begin
        if (!cq_empty_i) begin
          cq_pop_o = 1'b1;
          cmd_d    = cq_data_i;
          if (cq_data_i.kind == KIND_TONE || cq_data_i.kind == KIND_PAUSE) begin
            div_start = 1'b1;
            bst_d     = BS_DIV1;
          end else begin
            t_d   = '0;
            bst_d = BS_OUT;
          end
        end
      end
      BS_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = div_quo;
          div_dvs   = cmd_q.tempo;
          bst_d     = BS_DIV2;
        end
      end
      BS_DIV2: begin
        if (div_done) begin
          t_d   = 13'(div_quo);
          bst_d = BS_OUT;
        end
      end
      BS_OUT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          bst_d   = BS_IDLE;
        end
      end
      default: bst_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bst_q <= BS_IDLE;
    else         bst_q <= bst_d;
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    t_q   <= t_d;
  end

  // two-entry result queue
  logic oq_pop;
  assign oq_full = oq_cnt_q == 2'd2;
  assign empty_o = oq_cnt_q == 2'd0;
  assign oq_pop  = pop_i && !empty_o;
  assign res_o   = oq_mem_q[oq_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) oq_wp_q <= !oq_wp_q;
      if (oq_pop)  oq_rp_q <= !oq_rp_q;
      if (oq_push && !oq_pop)      oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (oq_pop && !oq_push) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_mem_q[oq_wp_q] <= res_new;
  end

endmodule
`default_nettype wire
